[rtl/olir_pkg.sv]
// Package for the ordered list engine: request modes, result status codes
// and sequencer states. No dependencies.
`default_nettype none

package olir_pkg;

  typedef enum logic [2:0] {
    MODE_READ   = 3'd0,
    MODE_WRITE  = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_APPEND = 3'd3,
    MODE_REMOVE = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_e;

endpackage

`default_nettype wire

[rtl/olir_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module olir_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/ordered_list_insert_remove_top.sv]
// Ordered list engine, top level: request sequencer and element count.
// Uses olir_pkg and olir_ram.
// Overwrite and rejected words are answered from idle, a read passes through
// S_READ, and insert/append/remove shift words in S_SHIFT; one RAM access of
// each kind per cycle sets the shift rate. Busy stays high while a word is in
// work; the result is strobed on done_o for one cycle and cannot be held.
// Reset clears the count and the sequencer; the RAM contents are not cleared.
`default_nettype none

module ordered_list_insert_remove_top
  import olir_pkg::*;
#(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [7:0]  index_i,
  input  wire logic [31:0] value_i,
  output      logic        done_o,
  output      logic [31:0] read_value_o,
  output      logic [8:0]  count_o,
  output      logic [1:0]  status_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > 8) ? CW : 8;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            ptr_q, ptr_d;
  logic [CW-1:0]            pos_q, pos_d;
  logic [AW-1:0]            wr_q, wr_d;
  logic                     pend_q, pend_d;
  logic                     up_q, up_d;
  logic [ELEMENT_WIDTH-1:0] val_q, val_d;
  logic                     done_q, done_d;
  logic [31:0]              rv_q, rv_d;
  logic [8:0]               rcnt_q, rcnt_d;
  status_e                  rst_q, rst_d;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  logic [WW-1:0]            idx_w, cnt_w;
  logic                     full;
  logic [CW-1:0]            ptr_m1;

  olir_ram #(.DEPTH(CAPACITY), .WIDTH(ELEMENT_WIDTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign idx_w  = WW'(index_i);
  assign cnt_w  = WW'(count_q);
  assign full   = (count_q == CW'(CAPACITY));
  assign ptr_m1 = ptr_q - CW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    wr_d      = wr_q;
    pend_d    = pend_q;
    up_d      = up_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rv_d      = rv_q;
    rcnt_d    = rcnt_q;
    rst_d     = rst_q;
    mem_we    = 1'b0;
    mem_waddr = wr_q;
    mem_wdata = mem_rdata;
    mem_raddr = AW'(index_i);

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          val_d  = ELEMENT_WIDTH'(value_i);
          rv_d   = '0;
          rst_d  = STAT_OK;
          rcnt_d = 9'(count_q);
          unique case (mode_i)
            MODE_READ: begin
              if (idx_w < cnt_w) begin
                state_d = S_READ;
              end else begin
                rst_d  = STAT_RANGE;
                done_d = 1'b1;
              end
            end
            MODE_WRITE: begin
              done_d = 1'b1;
              if (idx_w < cnt_w) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(index_i);
                mem_wdata = ELEMENT_WIDTH'(value_i);
              end else begin
                rst_d = STAT_RANGE;
              end
            end
            MODE_INSERT: begin
              if (idx_w > cnt_w) begin
                rst_d  = STAT_RANGE;
                done_d = 1'b1;
              end else if (full) begin
                rst_d  = STAT_FULL;
                done_d = 1'b1;
              end else begin
                pos_d   = CW'(idx_w);
                ptr_d   = count_q;
                up_d    = 1'b1;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            MODE_APPEND: begin
              if (full) begin
                rst_d  = STAT_FULL;
                done_d = 1'b1;
              end else begin
                pos_d   = count_q;
                ptr_d   = count_q;
                up_d    = 1'b1;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            MODE_REMOVE: begin
              if (idx_w < cnt_w) begin
                ptr_d   = CW'(idx_w + WW'(1));
                up_d    = 1'b0;
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end else begin
                rst_d  = STAT_RANGE;
                done_d = 1'b1;
              end
            end
            default: begin
              rst_d  = STAT_RANGE;
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        rv_d    = 32'(mem_rdata);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_SHIFT: begin
        mem_we = pend_q;
        pend_d = 1'b0;
        if (up_q) begin
          // move word ptr-1 up to ptr, then drop the new word in at pos
          mem_raddr = ptr_m1[AW-1:0];
          if (ptr_q > pos_q) begin
            wr_d   = ptr_q[AW-1:0];
            ptr_d  = ptr_m1;
            pend_d = 1'b1;
          end else if (!pend_q) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q[AW-1:0];
            mem_wdata = val_q;
            count_d   = count_q + CW'(1);
            rcnt_d    = 9'(count_d);
            done_d    = 1'b1;
            state_d   = S_IDLE;
          end
        end else begin
          // move word ptr down to ptr-1
          mem_raddr = ptr_q[AW-1:0];
          if (ptr_q < count_q) begin
            wr_d   = ptr_m1[AW-1:0];
            ptr_d  = ptr_q + CW'(1);
            pend_d = 1'b1;
          end else if (!pend_q) begin
            count_d = count_q - CW'(1);
            rcnt_d  = 9'(count_d);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    wr_q   <= wr_d;
    up_q   <= up_d;
    val_q  <= val_d;
    rv_q   <= rv_d;
    rcnt_q <= rcnt_d;
    rst_q  <= rst_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rv_q;
  assign count_o      = rcnt_q;
  assign status_o     = rst_q;

endmodule

`default_nettype wire

[rtl/olir_checker.sv]
// Port-level checks for the ordered list engine, bound to the top level.
// Uses olir_pkg.
`default_nettype none

module olir_checker
  import olir_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [31:0] read_value_o,
  input wire logic [8:0]  count_o,
  input wire logic [1:0]  status_o
);

  a_busy_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> (busy_o || done_o))
    else $error("busy dropped without a result word");

  a_accept_leads_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted word neither in work nor answered");

  a_fail_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_OK)) |-> (read_value_o == 32'd0))
    else $error("failed request returned data");

  a_full_at_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_FULL)) |-> (count_o == 9'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind ordered_list_insert_remove_top olir_checker #(.CAPACITY(CAPACITY)) u_olir_checker (.*);

`default_nettype wire
